// ===== hdl/y4h_pkg.sv =====
// ----------------------------------------------------------------------------
// y4h_pkg : shared types and constants of the half-scale YUV converter
// Queue entry format, register indexes and fixed frame limits.
// ----------------------------------------------------------------------------
package y4h_pkg;

    // Width of the arithmetic used for the group-count compare.
    localparam int CALC_W       = 14;
    // Config register width and row counter width.
    localparam int CFG_W        = 12;
    localparam int ROW_W        = 11;
    localparam int MIN_WIDTH    = 4;
    localparam int HEIGHT_LIMIT = 2048;

    // Register indexes on the APB port (byte address bit 2).
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef enum logic {
        K_WRITE = 1'b0,   // store {U, luma} of a first-row group
        K_EMIT  = 1'b1    // read a stored pair and produce one result
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic       half;      // which group of the stored pair
        logic [7:0] byte_a;    // U on write, V mean on emit
        logic [7:0] byte_b;    // first luma on write
        logic       row_end;
        logic       frame_end;
    } t_op;

    localparam int OP_W = $bits(t_op);

endpackage

// ===== hdl/y4h_front.sv =====
// ----------------------------------------------------------------------------
// y4h_front : row/column tracking and classification of incoming groups
// Turns each accepted group into a store write, a result request or nothing.
// ----------------------------------------------------------------------------
module y4h_front
    import y4h_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [CFG_W-1:0]                    i_frame_width,
    input  logic [CFG_W-1:0]                    i_frame_height,
    input  logic                                i_accept,
    input  logic [7:0]                          i_chroma,
    input  logic [7:0]                          i_luma,
    output logic                                o_push,
    output t_op                                 o_op,
    output logic [$clog2(MAX_WIDTH/2)-2:0]      o_addr
);

    localparam int COL_W = $clog2(MAX_WIDTH / 2);

    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [7:0]       r_hold;

    logic [CALC_W-1:0] width_q, width_c, groups;
    logic [CFG_W-1:0]  height_c, paired, row_next;
    logic              last_col, last_row, in_pair, frame_done;
    logic [8:0]        v_sum;

    always_comb begin
        width_q = CALC_W'({i_frame_width[CFG_W-1:2], 2'b00});
        if (width_q < CALC_W'(MIN_WIDTH)) begin
            width_c = CALC_W'(MIN_WIDTH);
        end else if (width_q > CALC_W'(MAX_WIDTH)) begin
            width_c = CALC_W'(MAX_WIDTH);
        end else begin
            width_c = width_q;
        end
        groups = width_c >> 1;

        if (i_frame_height == '0) begin
            height_c = CFG_W'(1);
        end else if (i_frame_height > CFG_W'(HEIGHT_LIMIT)) begin
            height_c = CFG_W'(HEIGHT_LIMIT);
        end else begin
            height_c = i_frame_height;
        end
        paired   = {height_c[CFG_W-1:1], 1'b0};
        row_next = CFG_W'(r_row) + CFG_W'(1);

        last_col   = (CALC_W'(r_col) + CALC_W'(1)) >= groups;
        last_row   = row_next >= height_c;
        in_pair    = CFG_W'(r_row) < paired;
        frame_done = last_col && (row_next >= paired);
        v_sum      = {1'b0, r_hold} + {1'b0, i_chroma};

        if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : row_next[ROW_W-1:0];
        end else begin
            n_col = r_col + COL_W'(1);
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_hold <= '0;
        end else if (i_accept) begin
            r_col <= n_col;
            r_row <= n_row;
            // hold V of the even group on a second row
            if (in_pair && r_row[0] && !r_col[0]) begin
                r_hold <= i_chroma;
            end
        end
    end

    assign o_push         = i_accept && in_pair && (!r_row[0] || r_col[0]);
    assign o_op.kind      = r_row[0] ? K_EMIT : K_WRITE;
    assign o_op.half      = r_col[0];
    assign o_op.byte_a    = r_row[0] ? v_sum[8:1] : i_chroma;
    assign o_op.byte_b    = i_luma;
    assign o_op.row_end   = last_col;
    assign o_op.frame_end = frame_done;
    assign o_addr         = r_col[COL_W-1:1];

endmodule

// ===== hdl/y4h_queue.sv =====
// ----------------------------------------------------------------------------
// y4h_queue : small synchronous FIFO between front and back
// First-word-fall-through; full flag drives input backpressure.
// ----------------------------------------------------------------------------
module y4h_queue #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = $clog2(DEPTH);

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [PTR_W:0]   r_count;

    assign o_full  = r_count == (PTR_W+1)'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (PTR_W+1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (PTR_W+1)'(1);
            end
        end
    end

endmodule

// ===== hdl/y4h_back.sv =====
// ----------------------------------------------------------------------------
// y4h_back : line store, U averaging and output register
// Executes queued store writes and result reads in order.
// ----------------------------------------------------------------------------
module y4h_back
    import y4h_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_q_valid,
    input  t_op                                 i_q_op,
    input  logic [$clog2(MAX_WIDTH/2)-2:0]      i_q_addr,
    output logic                                o_q_pop,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [31:0]                         o_data,
    output logic                                o_row_end,
    output logic                                o_frame_end
);

    localparam int WORDS  = MAX_WIDTH / 4;

    // one word holds the {U, luma} pair of an even and an odd group
    logic [31:0] r_mem [WORDS];
    logic [31:0] r_rd;

    logic r_s1_valid;
    t_op  r_s1_op;
    logic r_out_valid;
    logic [31:0] r_out_data;
    logic r_out_row_end, r_out_frame_end;

    logic out_free, s1_adv, s1_free, pop, do_write, do_read;
    logic [8:0] u_sum;

    always_comb begin
        out_free = !r_out_valid || i_ready;
        s1_adv   = r_s1_valid && out_free;
        s1_free  = !r_s1_valid || s1_adv;
        pop      = i_q_valid && ((i_q_op.kind == K_WRITE) || s1_free);
        do_write = pop && (i_q_op.kind == K_WRITE);
        do_read  = pop && (i_q_op.kind == K_EMIT);
        u_sum    = {1'b0, r_rd[15:8]} + {1'b0, r_rd[31:24]};
    end

    assign o_q_pop = pop;

    always_ff @(posedge i_clk) begin
        if (do_write) begin
            if (i_q_op.half) begin
                r_mem[i_q_addr][31:16] <= {i_q_op.byte_a, i_q_op.byte_b};
            end else begin
                r_mem[i_q_addr][15:0]  <= {i_q_op.byte_a, i_q_op.byte_b};
            end
        end
        if (do_read) begin
            r_rd <= r_mem[i_q_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= do_read || (r_s1_valid && !s1_adv);
            r_out_valid <= s1_adv || (r_out_valid && !i_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_read) begin
            r_s1_op <= i_q_op;
        end
        if (s1_adv) begin
            r_out_data      <= {r_s1_op.byte_a, r_rd[23:16], u_sum[8:1], r_rd[7:0]};
            r_out_row_end   <= r_s1_op.row_end;
            r_out_frame_end <= r_s1_op.frame_end;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_data      = r_out_data;
    assign o_row_end   = r_out_row_end;
    assign o_frame_end = r_out_frame_end;

endmodule

// ===== hdl/yuv420_to_yuv422_half_scale.sv =====
// ----------------------------------------------------------------------------
// yuv420_to_yuv422_half_scale : YUV420 groups in, half-scale YUYV out
// Halves a packed YUV420 frame in both directions and emits Y U Y V words.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake            Payload
// s_        in   tvalid/tready        tdata: chroma, luma_first, luma_second
// m_        out  tvalid/tready        tdata: luma_left, u_mean, luma_right,
//                                      v_mean; tlast: row_end; tuser: frame_end
// APB       in   psel/penable/pready  0x0 frame_width, 0x4 frame_height
//
// One input group is taken every cycle while the queue has room. A result
// leaves via the queue, the store read register and the output register
// after the odd group that completes it, one per two second-row groups; the
// single-port line store takes one write or one read per cycle. Reset clears
// counters and handshake state and loads the default frame size; the line
// store holds no reset value and needs no clearing pass. Output stalls fill
// the output register, the read stage and then the queue, then s_tready drops.
// ----------------------------------------------------------------------------
module yuv420_to_yuv422_half_scale
    import y4h_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // stream in
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,    // [7:0] chroma, [15:8] luma_first, [23:16] luma_second
    // stream out
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,    // [7:0] luma_left, [15:8] u_mean, [23:16] luma_right,
                                      // [31:24] v_mean
    output logic        o_m_tlast,    // row_end
    output logic        o_m_tuser,    // [0] frame_end
    // register port
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);

    localparam int ADDR_W = $clog2(MAX_WIDTH / 2) - 1;

    logic [CFG_W-1:0] r_frame_width, r_frame_height;

    logic              accept, push, q_full, q_valid, q_pop;
    t_op               front_op, q_op;
    logic [ADDR_W-1:0] front_addr, q_addr;

    // ------------------------------------------------------------------
    // Configuration: written on the access phase, read back unbuffered
    // ------------------------------------------------------------------
    assign o_pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= CFG_W'(640);
            r_frame_height <= CFG_W'(480);
        end else if (i_psel && i_penable && i_pwrite) begin
            unique case (i_paddr[2])
                REG_FRAME_WIDTH:  r_frame_width  <= i_pwdata[CFG_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= i_pwdata[CFG_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb begin
        unique case (i_paddr[2])
            REG_FRAME_WIDTH:  o_prdata = 32'(r_frame_width);
            REG_FRAME_HEIGHT: o_prdata = 32'(r_frame_height);
            default:          o_prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Front: accept whenever the queue has room; even second-row groups and odd last rows push nothing
    // ------------------------------------------------------------------
    assign o_s_tready = !q_full;
    assign accept     = i_s_tvalid && !q_full;

    y4h_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .i_accept       (accept),
        .i_chroma       (i_s_tdata[7:0]),
        .i_luma         (i_s_tdata[15:8]),
        .o_push         (push),
        .o_op           (front_op),
        .o_addr         (front_addr)
    );

    // ------------------------------------------------------------------
    // Queue: decouple classification from store access and output stalls
    // ------------------------------------------------------------------
    logic [OP_W+ADDR_W-1:0] q_in, q_out;

    assign q_in   = {front_addr, front_op};
    assign q_op   = t_op'(q_out[OP_W-1:0]);
    assign q_addr = q_out[OP_W+ADDR_W-1:OP_W];

    y4h_queue #(
        .WIDTH (OP_W + ADDR_W),
        .DEPTH (4)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    // ------------------------------------------------------------------
    // Back: line store writes, pair reads, averaging, output register
    // ------------------------------------------------------------------
    y4h_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_op      (q_op),
        .i_q_addr    (q_addr),
        .o_q_pop     (q_pop),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_data      (o_m_tdata),
        .o_row_end   (o_m_tlast),
        .o_frame_end (o_m_tuser)
    );

endmodule

// ===== bench/tb_yuv420_to_yuv422_half_scale.sv =====
// ----------------------------------------------------------------------------
// tb_yuv420_to_yuv422_half_scale : self-checking bench for the half-scale
// YUV420 to YUYV converter
// Drives packed chroma/luma groups into the stream input and programs the frame
// size over APB. A behavioural copy of the converter predicts every YUYV word.
// A checker compares each output transfer field by field. Directed cases cover
// register reset values, field extremes, odd and clamped heights, mid-frame
// size changes, a clamped width and one long receiver hold-off. Random frames
// follow, with idle bursts on both sides.
// ----------------------------------------------------------------------------
module tb_yuv420_to_yuv422_half_scale;
    timeunit 1ns;
    timeprecision 1ps;

    import y4h_pkg::*;

    localparam int MAX_W         = 2048;
    localparam int STORE_DEPTH   = MAX_W / 2;
    localparam int HOLD_CYCLES   = 300;    // long receiver hold-off
    localparam int IDLE_LIMIT    = 2000;   // cycles without any transfer
    localparam int SETTLE_CYCLES = 10;     // pipeline latency with margin
    localparam int RANDOM_GROUPS = 380;
    localparam int REPORT_MAX    = 10;

    // One expected output word, fields named as they leave the block.
    typedef struct packed {
        logic [7:0] luma_left;
        logic [7:0] u_mean;
        logic [7:0] luma_right;
        logic [7:0] v_mean;
        logic       row_end;
        logic       frame_end;
    } t_yuyv_word;

    // ------------------------------------------------------------------------
    // Clock, reset and the block's inputs, all known from time zero
    // ------------------------------------------------------------------------
    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        s_valid = 1'b0;
    logic [23:0] s_data  = '0;
    logic        m_ready = 1'b1;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;

    logic        s_ready;
    logic        m_valid;
    logic [31:0] m_data;
    logic        m_last;
    logic        m_user;
    logic [31:0] prdata;
    logic        pready;

    always #5 clk = ~clk;

    yuv420_to_yuv422_half_scale #(
        .MAX_WIDTH (MAX_W)
    ) uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (s_ready),
        .i_s_tdata  (s_data),     // [7:0] chroma, [15:8] luma_first, [23:16] luma_second
        .o_m_tvalid (m_valid),
        .i_m_tready (m_ready),
        .o_m_tdata  (m_data),     // [7:0] luma_left, [15:8] u_mean, [23:16] luma_right,
                                  // [31:24] v_mean
        .o_m_tlast  (m_last),     // row_end
        .o_m_tuser  (m_user),     // [0] frame_end
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .o_prdata   (prdata),
        .o_pready   (pready)
    );

    // ------------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------------
    t_yuyv_word pending_words[$];     // predicted words not yet seen at the output
    int         mismatches   = 0;
    int         groups_sent  = 0;
    int         idle_cycles  = 0;
    bit         calm         = 1'b0;  // no idle bursts on either side while set
    bit         hold_off_req = 1'b0;  // ask the receiver for one long hold-off

    // Converter copy: registers, line store and counters after reset.
    logic [CFG_W-1:0] cfg_width  = 12'd640;
    logic [CFG_W-1:0] cfg_height = 12'd480;
    logic [15:0]      line_copy [STORE_DEPTH];   // {U, first luma} per group
    logic [9:0]       grp_col    = '0;
    logic [ROW_W-1:0] row_idx    = '0;
    logic [7:0]       v_hold     = '0;           // V of the even group, second row

    // Groups in one source row: low two width bits dropped, clamped both ways.
    function automatic int unsigned row_groups();
        int unsigned span;
        span = cfg_width & ~32'd3;
        if (span < MIN_WIDTH) span = MIN_WIDTH;
        if (span > MAX_W) span = MAX_W & ~3;
        return span / 2;
    endfunction

    // Rows in one source frame: zero taken as one, clamped at the top.
    function automatic int unsigned frame_rows();
        int unsigned rows;
        rows = cfg_height;
        if (rows < 1) rows = 1;
        if (rows > HEIGHT_LIMIT) rows = HEIGHT_LIMIT;
        return rows;
    endfunction

    // Advance the converter copy by one group; returns 1 when a word is due.
    function automatic bit predict_yuyv(input logic [7:0] chroma, input logic [7:0] luma,
                                        output t_yuyv_word word);
        int unsigned groups;
        int unsigned rows;
        int unsigned paired;
        logic [15:0] even_entry;
        logic [15:0] odd_entry;
        logic [8:0]  sum_u;
        logic [8:0]  sum_v;
        bit          last_col;
        bit          last_row;
        bit          emit;
        groups   = row_groups();
        rows     = frame_rows();
        paired   = rows & ~32'd1;
        last_col = (grp_col + 1) >= groups;
        last_row = (row_idx + 1) >= rows;
        emit     = 1'b0;
        word     = '0;
        // An odd last row falls outside the paired rows and is dropped.
        if (row_idx < paired) begin
            if (!row_idx[0]) begin
                line_copy[grp_col] = {chroma, luma};
            end else if (!grp_col[0]) begin
                v_hold = chroma;
            end else begin
                even_entry      = line_copy[grp_col - 10'd1];
                odd_entry       = line_copy[grp_col];
                sum_u           = even_entry[15:8] + odd_entry[15:8];
                sum_v           = v_hold + chroma;
                word.luma_left  = even_entry[7:0];
                word.u_mean     = sum_u[8:1];
                word.luma_right = odd_entry[7:0];
                word.v_mean     = sum_v[8:1];
                word.row_end    = last_col;
                word.frame_end  = last_col && (row_idx + 1) >= paired;
                emit            = 1'b1;
            end
        end
        if (last_col) begin
            grp_col = '0;
            row_idx = last_row ? '0 : row_idx + 1'b1;
        end else begin
            grp_col = grp_col + 1'b1;
        end
        return emit;
    endfunction

    // Count a failure; report only the first few in full.
    task automatic note_failure(input string msg);
        mismatches++;
        if (mismatches <= REPORT_MAX) $display("mismatch: %s", msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
            note_failure($sformatf("%s expected %0h, got %0h", name, want, got));
    endtask

    // ------------------------------------------------------------------------
    // Stream input: one transfer per call, optional idle burst in front
    // ------------------------------------------------------------------------
    task automatic send_group(input logic [7:0] chroma, input logic [7:0] luma_a,
                              input logic [7:0] luma_b);
        t_yuyv_word word;
        int         gap;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 8);
            s_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= {luma_b, luma_a, chroma};
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        if (predict_yuyv(chroma, luma_a, word)) pending_words.push_back(word);
        groups_sent++;
        @(negedge clk);
    endtask

    task automatic send_random_group();
        send_group($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
    endtask

    // Whole frames at the current size, so no row pair is left half done.
    task automatic send_frames(input int frames);
        repeat (frames * row_groups() * frame_rows()) send_random_group();
    endtask

    // Drop valid, wait for every predicted word, then let the pipeline settle.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_words.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // APB: setup cycle, access cycle, then the bus is released
    // ------------------------------------------------------------------------
    task automatic check_register(input logic sel, input logic [CFG_W-1:0] want);
        logic [31:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {sel, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        got = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        check_field(sel == REG_FRAME_WIDTH ? "frame_width" : "frame_height",
                    want, got[CFG_W-1:0]);
    endtask

    task automatic write_register(input logic sel, input logic [CFG_W-1:0] value);
        logic [31:0] bus_word;
        bus_word = $urandom;             // upper bits are don't-care to the block
        bus_word[CFG_W-1:0] = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= bus_word;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (sel == REG_FRAME_WIDTH) cfg_width = value;
        else cfg_height = value;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        check_register(sel, value);
    endtask

    task automatic set_frame_size(input logic [CFG_W-1:0] width,
                                  input logic [CFG_W-1:0] height);
        write_register(REG_FRAME_WIDTH, width);
        write_register(REG_FRAME_HEIGHT, height);
    endtask

    // ------------------------------------------------------------------------
    // Receiver pacing: random stall bursts, or one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin : sink_pacing
        int burst;
        forever begin
            @(negedge clk);
            if (hold_off_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_off_req = 1'b0;
                m_ready <= 1'b1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                burst = $urandom_range(1, 8);
                m_ready <= 1'b0;
                repeat (burst) @(negedge clk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output checker: every transfer against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : result_check
        t_yuyv_word want;
        if (rst_n && m_valid && m_ready) begin
            if (pending_words.size() == 0) begin
                note_failure($sformatf("unexpected word %0h last %0b user %0b",
                                       m_data, m_last, m_user));
            end else begin
                want = pending_words.pop_front();
                check_field("luma_left", want.luma_left, m_data[7:0]);
                check_field("u_mean", want.u_mean, m_data[15:8]);
                check_field("luma_right", want.luma_right, m_data[23:16]);
                check_field("v_mean", want.v_mean, m_data[31:24]);
                check_field("row_end", want.row_end, m_last);
                check_field("frame_end", want.frame_end, m_user);
            end
        end
    end

    // Watchdog: end the run if nothing moves on any port for too long.
    always @(posedge clk) begin : watchdog
        if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("yuv420_to_yuv422_half_scale test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Registers must read back their reset values before anything is written.
    task automatic test_reset_values();
        check_register(REG_FRAME_WIDTH, 12'd640);
        check_register(REG_FRAME_HEIGHT, 12'd480);
    endtask

    // Saturated and zero chroma, odd sums that truncate, luma at both ends.
    task automatic test_field_extremes();
        wait_idle();
        set_frame_size(12'd8, 12'd2);
        send_group(8'hFF, 8'h00, 8'hFF);
        send_group(8'hFF, 8'hFF, 8'h00);
        send_group(8'h00, 8'hA5, 8'h5A);
        send_group(8'hFF, 8'h5A, 8'hA5);
        send_group(8'hFF, 8'h00, 8'h00);
        send_group(8'hFF, 8'hFF, 8'hFF);
        send_group(8'h00, 8'h12, 8'h34);
        send_group(8'h01, 8'h56, 8'h78);
    endtask

    // Width below four is taken as four; the odd third row is swallowed.
    task automatic test_odd_height();
        wait_idle();
        set_frame_size(12'd1, 12'd3);
        send_frames(1);
    endtask

    // Height above the limit clamps, so the first pair does not end the frame.
    // Then shrink the height to the row counter value: the next row closes it.
    task automatic test_tall_height();
        wait_idle();
        set_frame_size(12'd4, 12'hFFF);
        repeat (4) send_random_group();
        wait_idle();
        write_register(REG_FRAME_HEIGHT, 12'd2);
        repeat (2) send_random_group();
    endtask

    // Narrow the row halfway through a second row: the column is already past
    // the new bound, so the next group ends the row and the frame.
    task automatic test_width_shrink_mid_frame();
        wait_idle();
        set_frame_size(12'd8, 12'd2);
        repeat (6) send_random_group();
        wait_idle();
        write_register(REG_FRAME_WIDTH, 12'd4);
        send_random_group();
    endtask

    // Full-range width clamps to the widest row, so part of a first row goes in
    // without ending it; a narrower width then closes the row at that column
    // and the second row reads back every stored group but that last one.
    task automatic test_wide_rows();
        wait_idle();
        set_frame_size(12'hFFF, 12'd2);
        repeat (24) send_random_group();
        wait_idle();
        write_register(REG_FRAME_WIDTH, 12'd48);
        repeat (25) send_random_group();
    endtask

    // Hold the receiver off while the sender keeps offering, so the block
    // fills up and pushes back on its input.
    task automatic test_backpressure();
        wait_idle();
        set_frame_size(12'd16, 12'd6);
        calm = 1'b1;
        hold_off_req = 1'b1;
        send_frames(3);
        calm = 1'b0;
    endtask

    // Random frame sizes, mostly small; whole frames per setting.
    task automatic test_random_frames();
        logic [CFG_W-1:0] width;
        logic [CFG_W-1:0] height;
        int               pick;
        int               frames;
        int               start;
        start = groups_sent;
        while (groups_sent - start < RANDOM_GROUPS) begin
            wait_idle();
            // Keep the tail of the run free of idling; elsewhere calm now and then.
            calm = (groups_sent - start > RANDOM_GROUPS - 120) || ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 9);
            if (pick < 7) width = $urandom_range(4, 48);
            else if (pick < 8) width = $urandom_range(0, 3);
            else width = $urandom_range(49, 300);
            pick = $urandom_range(0, 9);
            if (pick < 5) height = $urandom_range(2, 8);
            else if (pick < 7) height = $urandom_range(0, 1);
            else if (pick < 9) height = 2 * $urandom_range(1, 5) + 1;
            else height = $urandom_range(9, 24);
            // Keep wide rows short so no single setting dominates the run.
            if (width > 48) height = $urandom_range(0, 3);
            set_frame_size(width, height);
            frames = (row_groups() * frame_rows() > 100) ? 1 : $urandom_range(1, 3);
            send_frames(frames);
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin : run_tests
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_reset_values();
        test_field_extremes();
        test_odd_height();
        test_tall_height();
        test_width_shrink_mid_frame();
        test_wide_rows();
        test_backpressure();
        test_random_frames();
        wait_idle();
        if (mismatches == 0 && pending_words.size() == 0) begin
            $display("yuv420_to_yuv422_half_scale test passed");
        end else begin
            $display("yuv420_to_yuv422_half_scale test failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/y4h_pkg.sv
hdl/y4h_front.sv
hdl/y4h_queue.sv
hdl/y4h_back.sv
hdl/yuv420_to_yuv422_half_scale.sv
bench/tb_yuv420_to_yuv422_half_scale.sv
